FILE: src/gebm_pkg.sv
// ----------------------------------------------------------------------------
// gebm_pkg
// shared types and constants of the grid edge blockage map
// ----------------------------------------------------------------------------
`default_nettype none

package gebm_pkg;

    // field widths
    localparam int ID_W        = 12;
    localparam int DIM_W       = 7;
    localparam int COUNT_W     = 13;
    localparam int FLAG_W      = 4;
    localparam int STATUS_W    = 2;

    // stream and configuration port widths
    localparam int IN_DATA_W   = 32;
    localparam int IN_USER_W   = 1;
    localparam int OUT_DATA_W  = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    // default map depth
    localparam int DEF_MAX_NODES = 4096;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_NODE_COUNT  = 2'd2;

    // configuration reset values
    localparam logic [DIM_W-1:0]   RST_GRID_WIDTH  = 7'd64;
    localparam logic [DIM_W-1:0]   RST_GRID_HEIGHT = 7'd64;
    localparam logic [COUNT_W-1:0] RST_NODE_COUNT  = 13'd4096;

    // commands
    localparam logic CMD_SET   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BOUNDS  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_ADJ = 2'd2;

    // edge directions, also the flag bit index
    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_DIV_COL,
        S_DIV_ROW,
        S_DIR,
        S_RD_A,
        S_RD_B,
        S_DONE
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load_item;
        logic div_start;
        logic div_row;
        logic save_col;
        logic save_row;
        logic save_dir;
        logic set_bounds;
        logic set_not_adj;
        logic take_flag;
        logic rd_second;
        logic wr_first;
        logic wr_second;
        logic clr_step;
        logic load_out;
    } ctrl_t;

    // datapath to controller status
    typedef struct packed {
        logic bad;
        logic div_done;
        logic adjacent;
        logic is_query;
        logic clear_done;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

FILE: src/gebm_ram.sv
// ----------------------------------------------------------------------------
// gebm_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module gebm_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: src/gebm_div.sv
// ----------------------------------------------------------------------------
// gebm_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module gebm_div (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [gebm_pkg::ID_W-1:0]  dividend,
    input  wire logic [gebm_pkg::DIM_W-1:0] divisor,
    output logic                          done,
    output logic      [gebm_pkg::ID_W-1:0]  quotient,
    output logic      [gebm_pkg::DIM_W-1:0] remainder
);

    import gebm_pkg::*;

    localparam int CNT_W = $clog2(ID_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ID_W - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [ID_W-1:0]  work_reg, work_next;
    logic [DIM_W-1:0] rem_reg, rem_next;
    logic [DIM_W-1:0] dvsr_reg, dvsr_next;

    logic [DIM_W:0]   trial;
    logic             fits;

    always_comb
    begin
        trial = {rem_reg, work_reg[ID_W-1]};
        fits  = trial >= {1'b0, dvsr_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            work_next = dividend;
            rem_next  = '0;
            dvsr_next = divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so the difference fits
            rem_next  = fits ? DIM_W'(trial - {1'b0, dvsr_reg}) : trial[DIM_W-1:0];
            work_next = {work_reg[ID_W-2:0], fits};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign done      = done_reg;
    assign quotient  = work_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

FILE: src/gebm_datapath.sv
// ----------------------------------------------------------------------------
// gebm_datapath
// item registers, bounds and adjacency checks, divider, flag map, result
// ----------------------------------------------------------------------------
`default_nettype none

module gebm_datapath #(
    parameter int MAX_NODES = gebm_pkg::DEF_MAX_NODES
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire gebm_pkg::ctrl_t                   ctrl,
    output gebm_pkg::stat_t                        stat,
    input  wire logic                              cfg_we,
    input  wire logic [gebm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [gebm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic [gebm_pkg::IN_DATA_W-1:0]    in_data,
    input  wire logic [gebm_pkg::IN_USER_W-1:0]    in_user,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic      [gebm_pkg::OUT_DATA_W-1:0]   out_data
);

    import gebm_pkg::*;

    localparam int ADDR_W = $clog2(MAX_NODES);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_NODES - 1);

    // configuration
    logic [DIM_W-1:0]   grid_width_reg, grid_height_reg;
    logic [COUNT_W-1:0] node_count_reg;

    // item
    logic               cmd_reg;
    logic [ID_W-1:0]    a_reg, b_reg;
    logic               val_reg;
    logic [DIM_W-1:0]   col_reg, row_reg;
    logic [1:0]         dir_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic               res_present_reg;

    // result register
    logic               out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic               out_present_reg;

    logic [ADDR_W-1:0]  clr_cnt_reg;

    // divider
    logic               div_done;
    logic [ID_W-1:0]    div_quot;
    logic [DIM_W-1:0]   div_rem;

    // map
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [FLAG_W-1:0]  ram_wdata, ram_rdata;
    logic [ADDR_W-1:0]  a_addr, b_addr;
    logic [FLAG_W-1:0]  mask_a, mask_b, upd_a, upd_b;

    logic               a_ok, b_ok;
    logic [ID_W:0]      a_ext, b_ext, w_ext;
    logic               is_left, is_right, is_up, is_down;
    logic [1:0]         dir_sel;

    // configuration writes, index beyond the list ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= RST_GRID_WIDTH;
            grid_height_reg <= RST_GRID_HEIGHT;
            node_count_reg  <= RST_NODE_COUNT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRID_WIDTH:  grid_width_reg  <= DIM_W'(cfg_data);
                CFG_GRID_HEIGHT: grid_height_reg <= DIM_W'(cfg_data);
                CFG_NODE_COUNT:  node_count_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // bounds
    always_comb
    begin
        a_ok = ({1'b0, a_reg} < node_count_reg) && (32'(a_reg) < 32'(MAX_NODES));
        b_ok = ({1'b0, b_reg} < node_count_reg) && (32'(b_reg) < 32'(MAX_NODES));
    end

    // neighbour position of b seen from a, tested left, right, up, down
    always_comb
    begin
        a_ext = {1'b0, a_reg};
        b_ext = {1'b0, b_reg};
        w_ext = (ID_W + 1)'(grid_width_reg);

        is_left  = (col_reg != '0) && (b_ext == a_ext - 1'b1);
        is_right = (col_reg < grid_width_reg - 1'b1) && (b_ext == a_ext + 1'b1);
        is_up    = (row_reg < grid_height_reg - 1'b1) && (b_ext == a_ext + w_ext);
        is_down  = (row_reg != '0) && (a_ext >= w_ext) && (b_ext == a_ext - w_ext);

        if (is_left)
            dir_sel = DIR_LEFT;
        else if (is_right)
            dir_sel = DIR_RIGHT;
        else if (is_up)
            dir_sel = DIR_UP;
        else
            dir_sel = DIR_DOWN;
    end

    gebm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ctrl.div_start),
        .dividend  (ctrl.div_row ? div_quot : a_reg),
        .divisor   (ctrl.div_row ? grid_height_reg : grid_width_reg),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // item and intermediate registers
    always_ff @(posedge clk)
    begin
        if (ctrl.load_item)
        begin
            cmd_reg         <= in_user[0];
            a_reg           <= in_data[ID_W-1:0];
            b_reg           <= in_data[2*ID_W-1:ID_W];
            val_reg         <= in_data[2*ID_W];
            res_status_reg  <= STATUS_OK;
            res_present_reg <= 1'b0;
        end
        if (ctrl.save_col)
            col_reg <= div_rem;
        if (ctrl.save_row)
            row_reg <= div_rem;
        if (ctrl.save_dir)
            dir_reg <= dir_sel;
        if (ctrl.set_bounds)
            res_status_reg <= STATUS_BOUNDS;
        if (ctrl.set_not_adj)
            res_status_reg <= STATUS_NOT_ADJ;
        if (ctrl.take_flag)
            res_present_reg <= ram_rdata[dir_reg];
        if (ctrl.load_out)
        begin
            out_status_reg  <= res_status_reg;
            out_present_reg <= res_present_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            if (ctrl.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (ctrl.clr_step)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // flag map, read-modify-write of both ends of the edge
    always_comb
    begin
        a_addr = ADDR_W'(a_reg);
        b_addr = ADDR_W'(b_reg);
        mask_a = FLAG_W'(1) << dir_reg;
        mask_b = FLAG_W'(1) << (dir_reg ^ 2'd1);
        upd_a  = val_reg ? (ram_rdata | mask_a) : (ram_rdata & ~mask_a);
        upd_b  = val_reg ? (ram_rdata | mask_b) : (ram_rdata & ~mask_b);

        ram_we    = ctrl.clr_step | ctrl.wr_first | ctrl.wr_second;
        ram_raddr = ctrl.rd_second ? b_addr : a_addr;
        if (ctrl.clr_step)
        begin
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else if (ctrl.wr_second)
        begin
            ram_waddr = b_addr;
            ram_wdata = upd_b;
        end
        else
        begin
            ram_waddr = a_addr;
            ram_wdata = upd_a;
        end
    end

    gebm_ram #(
        .WIDTH (FLAG_W),
        .DEPTH (MAX_NODES)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        stat.bad        = (grid_width_reg == '0) || (grid_height_reg == '0) || !a_ok || !b_ok;
        stat.div_done   = div_done;
        stat.adjacent   = is_left | is_right | is_up | is_down;
        stat.is_query   = (cmd_reg == CMD_QUERY);
        stat.clear_done = (clr_cnt_reg == LAST_ADDR);
        stat.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {{(OUT_DATA_W - STATUS_W - 1){1'b0}}, out_present_reg, out_status_reg};

endmodule

`default_nettype wire

FILE: src/gebm_ctrl.sv
// ----------------------------------------------------------------------------
// gebm_ctrl
// sequencer for clearing, checks, divisions and map accesses
// ----------------------------------------------------------------------------
`default_nettype none

module gebm_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire gebm_pkg::stat_t stat,
    output gebm_pkg::ctrl_t      ctrl
);

    import gebm_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:   if (stat.clear_done) state_next = S_IDLE;
            S_IDLE:    if (in_valid) state_next = S_CHECK;
            S_CHECK:   state_next = stat.bad ? S_DONE : S_DIV_COL;
            S_DIV_COL: if (stat.div_done) state_next = S_DIV_ROW;
            S_DIV_ROW: if (stat.div_done) state_next = S_DIR;
            S_DIR:     state_next = stat.adjacent ? S_RD_A : S_DONE;
            S_RD_A:    state_next = stat.is_query ? S_DONE : S_RD_B;
            S_RD_B:    state_next = S_DONE;
            S_DONE:    if (stat.out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        ctrl     = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                ctrl.clr_step = 1'b1;
            end
            S_IDLE:
            begin
                in_ready       = 1'b1;
                ctrl.load_item = in_valid;
            end
            S_CHECK:
            begin
                ctrl.set_bounds = stat.bad;
                ctrl.div_start  = !stat.bad;
            end
            S_DIV_COL:
            begin
                ctrl.save_col  = stat.div_done;
                ctrl.div_start = stat.div_done;
                ctrl.div_row   = 1'b1;
            end
            S_DIV_ROW:
            begin
                ctrl.save_row = stat.div_done;
            end
            S_DIR:
            begin
                ctrl.save_dir    = stat.adjacent;
                ctrl.set_not_adj = !stat.adjacent;
            end
            S_RD_A:
            begin
                ctrl.take_flag = stat.is_query;
                ctrl.wr_first  = !stat.is_query;
                ctrl.rd_second = !stat.is_query;
            end
            S_RD_B:
            begin
                ctrl.wr_second = 1'b1;
            end
            S_DONE:
            begin
                ctrl.load_out = stat.out_free;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: src/grid_edge_blockage_map_top.sv
// ----------------------------------------------------------------------------
// grid_edge_blockage_map_top
// map of blocked edges on a rectangular grid of nodes, set and query commands
// ----------------------------------------------------------------------------
// Each node of a grid_width by grid_height grid keeps four blocked flags (left,
// right, up, down) in a MAX_NODES by 4 bit map. A set command writes the flag
// on both ends of the edge between two neighbouring nodes; a query returns the
// flag as seen from the first node. Every transaction gives one result with
// status ok, out of bounds or not adjacent. After reset the map is cleared by
// a sweep over all MAX_NODES entries, one entry a cycle, during which no
// transaction is taken (configuration writes still are). Items are handled
// one at a time: no new item is taken until the last one has its result in
// the output register. An out-of-bounds command goes straight to its result;
// the others run the two 12-step restoring divisions (column from the width,
// row from the height) on the one shared divider, and a set then does a
// read-modify-write of both map entries through the single write port. A
// finished result waits in the output register while the next item is taken.
// Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_edge_blockage_map_top #(
    parameter int MAX_NODES = gebm_pkg::DEF_MAX_NODES
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    // configuration: 0 grid_width, 1 grid_height, 2 node_count
    input  wire logic                              cfg_we,
    input  wire logic [gebm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [gebm_pkg::CFG_DATA_W-1:0]   cfg_data,

    // command transactions
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // first_node [11:0], second_node [23:12], mine_value [24], zero fill
    input  wire logic [gebm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // cmd [0]: 0 set, 1 query
    input  wire logic [gebm_pkg::IN_USER_W-1:0]    s_axis_tuser,

    // result transactions
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // status [1:0], mine_present [2], zero fill
    output logic      [gebm_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    import gebm_pkg::*;

    ctrl_t ctrl;   // sequencer commands
    stat_t stat;   // datapath status

    // state machine: clearing sweep, then check, divide, decide, access map
    gebm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    // registers, divider, adjacency logic, flag map and result register
    gebm_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

FILE: verif/gebm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gebm_checker
// watches the grid edge blockage map channels and checks every result
// ----------------------------------------------------------------------------
// Mirrors the configuration writes and the blocked-flag map. Each accepted
// command is resolved against the mirrored map. Each result is compared
// in order against the oldest predicted reply.
// ----------------------------------------------------------------------------

module gebm_checker
    import gebm_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_DATA_W-1:0]   s_tdata,
    input  logic [IN_USER_W-1:0]   s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_DATA_W-1:0]  m_tdata,
    output int                     fail_count,
    output int                     pending
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                mine_present;
    } edge_reply_t;

    bit [FLAG_W-1:0]  blocked [MAX_NODES];
    bit [DIM_W-1:0]   grid_w = RST_GRID_WIDTH;
    bit [DIM_W-1:0]   grid_h = RST_GRID_HEIGHT;
    bit [COUNT_W-1:0] nodes  = RST_NODE_COUNT;

    edge_reply_t edge_replies[$];
    int          mismatches  = 0;
    int          outstanding = 0;

    assign fail_count = mismatches;
    assign pending    = outstanding;

    // resolve one command against the mirrored map, updating it on a set
    function automatic edge_reply_t apply_edge_cmd(input logic cmd,
                                                   input logic [ID_W-1:0] a,
                                                   input logic [ID_W-1:0] b,
                                                   input logic val);
        edge_reply_t     r;
        int              w;
        int              h;
        int              ai;
        int              bi;
        int              col;
        int              row;
        int              dir;
        logic [FLAG_W-1:0] near_bit;
        logic [FLAG_W-1:0] far_bit;
        w  = int'(grid_w);
        h  = int'(grid_h);
        ai = int'(a);
        bi = int'(b);
        r.status       = STATUS_OK;
        r.mine_present = 1'b0;
        if (w == 0 || h == 0 || ai >= int'(nodes) || bi >= int'(nodes)
            || ai >= MAX_NODES || bi >= MAX_NODES) begin
            r.status = STATUS_BOUNDS;
            return r;
        end
        col = ai % w;
        row = (ai / w) % h;
        dir = -1;
        if (col != 0 && bi == ai - 1)
            dir = int'(DIR_LEFT);
        else if (col < w - 1 && bi == ai + 1)
            dir = int'(DIR_RIGHT);
        else if (row < h - 1 && bi == ai + w)
            dir = int'(DIR_UP);
        else if (row != 0 && ai >= w && bi == ai - w)
            dir = int'(DIR_DOWN);
        if (dir < 0) begin
            r.status = STATUS_NOT_ADJ;
            return r;
        end
        near_bit = FLAG_W'(1) << dir;
        far_bit  = FLAG_W'(1) << (dir ^ 1);
        if (cmd == CMD_SET) begin
            if (val) begin
                blocked[ai] = blocked[ai] | near_bit;
                blocked[bi] = blocked[bi] | far_bit;
            end
            else begin
                blocked[ai] = blocked[ai] & ~near_bit;
                blocked[bi] = blocked[bi] & ~far_bit;
            end
        end
        else begin
            r.mine_present = |(blocked[ai] & near_bit);
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        edge_reply_t         want;
        logic [STATUS_W-1:0] got_status;
        logic                got_present;
        if (!rst_n) begin
            for (int i = 0; i < MAX_NODES; i++)
                blocked[i] = '0;
            grid_w = RST_GRID_WIDTH;
            grid_h = RST_GRID_HEIGHT;
            nodes  = RST_NODE_COUNT;
            edge_replies.delete();
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_GRID_WIDTH:  grid_w = cfg_data[DIM_W-1:0];
                    CFG_GRID_HEIGHT: grid_h = cfg_data[DIM_W-1:0];
                    CFG_NODE_COUNT:  nodes  = cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            // results first, so a result never matches a command of the same edge
            if (m_tvalid && m_tready) begin
                got_status  = m_tdata[STATUS_W-1:0];
                got_present = m_tdata[STATUS_W];
                if (edge_replies.size() == 0) begin
                    $error("unexpected result: status %0d mine_present %0d",
                           got_status, got_present);
                    mismatches++;
                end
                else begin
                    want = edge_replies.pop_front();
                    if (got_status !== want.status) begin
                        $error("status: expected %0d actual %0d", want.status, got_status);
                        mismatches++;
                    end
                    if (got_present !== want.mine_present) begin
                        $error("mine_present: expected %0d actual %0d",
                               want.mine_present, got_present);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                edge_replies.push_back(apply_edge_cmd(s_tuser[0],
                                                      s_tdata[ID_W-1:0],
                                                      s_tdata[2*ID_W-1:ID_W],
                                                      s_tdata[2*ID_W]));
        end
        outstanding = edge_replies.size();
    end

endmodule

FILE: verif/grid_edge_blockage_map_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_edge_blockage_map_top_tb
// set and query traffic for the grid edge blockage map
// ----------------------------------------------------------------------------
// Drives a directed set of corner cases and then random set/query commands
// over a range of grid shapes, with random gaps on both stream sides. The
// checker beside the block predicts every result and counts mismatches.
// ----------------------------------------------------------------------------

module grid_edge_blockage_map_top_tb;

    import gebm_pkg::*;

    // register index past the end of the list, writes to it are dropped
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    // covers the reset clearing sweep and the longest item, plus random stalls
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int ITEMS_PER_SETTING = 45;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;

    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_GRID_WIDTH;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // first_node [11:0], second_node [23:12], mine_value [24], zero fill
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    // cmd [0]: 0 set, 1 query
    logic [IN_USER_W-1:0]   s_axis_tuser = '0;

    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // status [1:0], mine_present [2], zero fill
    logic [OUT_DATA_W-1:0]  m_axis_tdata;

    int fail_count;
    int pending;

    // idle percentages of the sender and the receiver, changed per phase
    int send_idle_pct = 29;
    int recv_idle_pct = 67;

    int commands_sent = 0;
    int grid_settings = 0;
    int quiet_cycles  = 0;

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    grid_edge_blockage_map_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    gebm_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_axis_tvalid),
        .s_tready   (s_axis_tready),
        .s_tdata    (s_axis_tdata),
        .s_tuser    (s_axis_tuser),
        .m_tvalid   (m_axis_tvalid),
        .m_tready   (m_axis_tready),
        .m_tdata    (m_axis_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // receiver back-pressure, random per cycle
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog: ends the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // present one command; returns at the edge that accepts it, valid left high
    // so that a following command continues without a bubble
    task automatic send_cmd(input logic cmd, input logic [ID_W-1:0] a,
                            input logic [ID_W-1:0] b, input logic val);
        logic taken;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {{(IN_DATA_W - 2*ID_W - 1){1'b0}}, val, b, a};
        do
        begin
            @(negedge clk);
            taken = s_axis_tready;
            @(posedge clk);
        end
        while (!taken);
        commands_sent++;
    endtask

    // stop sending and let every predicted result come back
    task automatic drain_results;
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    // write all registers back to back, plus one write to the unused index
    task automatic program_grid(input int w, input int h, input int n);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_GRID_WIDTH;
        // upper bits beyond the 7-bit register are junk and must be dropped
        cfg_data  <= {6'($urandom), 7'(w)};
        @(posedge clk);
        cfg_index <= CFG_GRID_HEIGHT;
        cfg_data  <= {6'($urandom), 7'(h)};
        @(posedge clk);
        cfg_index <= CFG_NODE_COUNT;
        cfg_data  <= CFG_DATA_W'(n);
        @(posedge clk);
        cfg_index <= CFG_SPARE;
        cfg_data  <= CFG_DATA_W'($urandom);
        @(posedge clk);
        cfg_we    <= 1'b0;
        grid_settings++;
    endtask

    initial
    begin : stimulus
        int tab_w [9];
        int tab_h [9];
        int tab_n [9];
        int p;
        int c;
        int k;
        int idx;
        int w;
        int h;
        int n;
        int span;
        int dir;
        logic cmd;
        logic val;
        logic have_last;
        logic [ID_W-1:0] a;
        logic [ID_W-1:0] b;
        logic [ID_W-1:0] last_a;
        logic [ID_W-1:0] last_b;

        // grid shapes for the random part: thin, full, odd, short, oversize count
        tab_w = '{1, 64, 64, 7, 3, 13, 8, 64, 0};
        tab_h = '{64, 1, 64, 5, 3, 9, 8, 64, 0};
        tab_n = '{64, 64, 4096, 35, 9, 100, 8191, 8191, 0};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, on the reset grid of 64 by 64 first
        send_cmd(CMD_SET,   12'd0,    12'd1,    1'b1);   // block right edge of node 0
        send_cmd(CMD_QUERY, 12'd1,    12'd0,    1'b0);   // seen from the far end
        send_cmd(CMD_QUERY, 12'd0,    12'd1,    1'b1);   // mine_value ignored on query
        send_cmd(CMD_SET,   12'd4095, 12'd4031, 1'b1);   // down from the top corner
        send_cmd(CMD_QUERY, 12'd4031, 12'd4095, 1'b0);   // up, far end
        send_cmd(CMD_QUERY, 12'd4095, 12'd4094, 1'b0);   // left, never set
        send_cmd(CMD_QUERY, 12'd63,   12'd64,   1'b0);   // right across the row wrap
        send_cmd(CMD_QUERY, 12'd64,   12'd63,   1'b0);   // left from column zero
        send_cmd(CMD_QUERY, 12'd5,    12'd5,    1'b0);   // same node twice
        send_cmd(CMD_SET,   12'd1,    12'd0,    1'b0);   // clear from the other end
        send_cmd(CMD_QUERY, 12'd0,    12'd1,    1'b1);

        // 5 by 4 grid with fewer valid ids than nodes
        drain_results;
        program_grid(5, 4, 18);
        send_cmd(CMD_QUERY, 12'd18,   12'd13,   1'b0);   // first id out of range
        send_cmd(CMD_SET,   12'd0,    12'd4095, 1'b1);   // second id out of range
        send_cmd(CMD_SET,   12'd17,   12'd12,   1'b1);   // down, top row edge
        send_cmd(CMD_QUERY, 12'd12,   12'd17,   1'b0);   // up, far end
        send_cmd(CMD_QUERY, 12'd4,    12'd5,    1'b0);   // right off the last column
        send_cmd(CMD_QUERY, 12'd15,   12'd20,   1'b0);   // up off the top row, bounds

        // zero width, then zero height: everything is out of bounds
        drain_results;
        program_grid(0, 4, 20);
        send_cmd(CMD_QUERY, 12'd0,    12'd1,    1'b0);
        drain_results;
        program_grid(5, 0, 20);
        send_cmd(CMD_SET,   12'd0,    12'd1,    1'b1);

        // one column: only up and down exist
        drain_results;
        program_grid(1, 64, 64);
        send_cmd(CMD_SET,   12'd0,    12'd1,    1'b1);
        send_cmd(CMD_QUERY, 12'd1,    12'd0,    1'b0);

        // random part: three idle mixes, three grid settings each
        for (p = 0; p < 3; p++)
        begin
            send_idle_pct = (p == 0) ? 29 : (p == 1) ? 67 : 0;
            recv_idle_pct = (p == 0) ? 67 : (p == 1) ? 29 : 0;
            for (c = 0; c < 3; c++)
            begin
                idx = p * 3 + c;
                if (tab_w[idx] == 0)
                begin
                    w = $urandom_range(64, 1);
                    h = $urandom_range(64, 1);
                    n = ($urandom_range(1)) ? w * h : $urandom_range(4096, 1);
                end
                else
                begin
                    w = tab_w[idx];
                    h = tab_h[idx];
                    n = tab_n[idx];
                end
                drain_results;
                program_grid(w, h, n);

                span = n;
                if (w * h < span)
                    span = w * h;
                if (span > 4096)
                    span = 4096;
                have_last = 1'b0;
                last_a    = '0;
                last_b    = '0;

                for (k = 0; k < ITEMS_PER_SETTING; k++)
                begin
                    cmd = ($urandom_range(99) < 55) ? CMD_QUERY : CMD_SET;
                    val = 1'($urandom_range(1));
                    if ($urandom_range(99) < 15)
                    begin
                        // noise over the whole id range
                        a = ID_W'($urandom);
                        b = ID_W'($urandom);
                    end
                    else if (have_last && $urandom_range(99) < 35)
                    begin
                        // revisit a recent edge, either end
                        if ($urandom_range(1))
                        begin
                            a = last_a;
                            b = last_b;
                        end
                        else
                        begin
                            a = last_b;
                            b = last_a;
                        end
                    end
                    else
                    begin
                        // a valid node and one of its four would-be neighbours
                        a   = ID_W'($urandom_range(span - 1));
                        dir = $urandom_range(3);
                        case (dir)
                            int'(DIR_LEFT):  b = ID_W'(int'(a) - 1);
                            int'(DIR_RIGHT): b = ID_W'(int'(a) + 1);
                            int'(DIR_UP):    b = ID_W'(int'(a) + w);
                            default:         b = ID_W'(int'(a) - w);
                        endcase
                        last_a    = a;
                        last_b    = b;
                        have_last = 1'b1;
                    end
                    send_cmd(cmd, a, b, val);
                end
            end
        end

        drain_results;
        repeat (40) @(posedge clk);

        $display("covered %0d set and query commands over %0d grid settings,",
                 commands_sent, grid_settings);
        $display("including bound, adjacency, zero-size and row-wrap cases");
        if (fail_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: filelist.f
src/gebm_pkg.sv
src/gebm_ram.sv
src/gebm_div.sv
src/gebm_datapath.sv
src/gebm_ctrl.sv
src/grid_edge_blockage_map_top.sv
verif/gebm_checker.sv
verif/grid_edge_blockage_map_top_tb.sv
